// File: hdl/ilbm_body_packbits_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// ilbm_body_packbits_decoder_unit_defines
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef ILBM_BODY_PACKBITS_DECODER_UNIT_DEFINES_SVH
`define ILBM_BODY_PACKBITS_DECODER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ILBMPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ILBMPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ilbmpb_pkg.sv
// ----------------------------------------------------------------------------
// ilbmpb_pkg
// Constants, types and codes shared by the PackBits body decoder.
// ----------------------------------------------------------------------------
package ilbmpb_pkg;

  localparam int ROW_STRIDE  = 40;
  localparam int ROWS_MAX    = 256;
  localparam int PLANES_MAX  = 2;
  localparam int RUN_CAP     = 40;
  localparam int PLANE_SIZE  = ROW_STRIDE * ROWS_MAX;
  localparam int LEN_MAX     = (ROW_STRIDE < RUN_CAP) ? ROW_STRIDE : RUN_CAP;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 15;
  localparam int LEN_W       = 6;
  localparam int ROWS_W      = 9;
  localparam int PLANES_W    = 2;
  localparam int PLANE_W     = 1;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH  = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_PLANE_COUNT = 2'd2
  } reg_index_t;

  // One write burst: count words of the same value at consecutive addresses.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               done;
  } cmd_t;

endpackage

// File: hdl/ilbmpb_front.sv
// ----------------------------------------------------------------------------
// ilbmpb_front
// Takes body bytes, tracks the run and row state, and turns each data byte
// into a write burst for the back end.
// ----------------------------------------------------------------------------
`include "ilbm_body_packbits_decoder_unit_defines.svh"

module ilbmpb_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ilbmpb_pkg::BYTE_W-1:0]       code_byte,
  input  logic                                frame_start,
  input  logic                                cfg_valid,
  input  logic [ilbmpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ilbmpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                queue_full,
  output logic                                push,
  output ilbmpb_pkg::cmd_t                    cmd
);
  import ilbmpb_pkg::*;

  logic [LEN_W-1:0]    row_length;
  logic [ROWS_W-1:0]   row_count;
  logic [PLANES_W-1:0] plane_count;

  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   run_remaining, run_remaining_next;
  logic [LEN_W-1:0]    column_index, column_index_next;
  logic [ROWS_W-1:0]   row_index, row_index_next;
  logic [PLANE_W-1:0]  plane_index, plane_index_next;

  logic [LEN_W-1:0]    len;
  logic [ROWS_W-1:0]   rows;
  logic [PLANES_W-1:0] planes;

  phase_t              ph;
  logic [BYTE_W-1:0]   rr;
  logic [LEN_W-1:0]    col;
  logic [ROWS_W-1:0]   row;
  logic [PLANE_W-1:0]  pl;

  logic                take;
  logic                end_row;
  logic [LEN_W:0]      col_sum;
  logic [LEN_W-1:0]    room;
  logic [COUNT_W-1:0]  cnt;
  logic [PLANES_W-1:0] pl_sum;
  logic [ROWS_W:0]     row_sum;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (row_length == '0) begin
      len = LEN_W'(1);
    end else if (row_length > LEN_W'(LEN_MAX)) begin
      len = LEN_W'(LEN_MAX);
    end else begin
      len = row_length;
    end
    if (row_count == '0) begin
      rows = ROWS_W'(1);
    end else if (row_count > ROWS_W'(ROWS_MAX)) begin
      rows = ROWS_W'(ROWS_MAX);
    end else begin
      rows = row_count;
    end
    if (plane_count == '0) begin
      planes = PLANES_W'(1);
    end else if (plane_count > PLANES_W'(PLANES_MAX)) begin
      planes = PLANES_W'(PLANES_MAX);
    end else begin
      planes = plane_count;
    end
  end

  always_comb begin
    // frame_start restarts everything before the byte is looked at
    ph  = frame_start ? PH_CTRL : phase;
    rr  = frame_start ? '0 : run_remaining;
    col = frame_start ? '0 : column_index;
    row = frame_start ? '0 : row_index;
    pl  = frame_start ? '0 : plane_index;

    phase_next         = ph;
    run_remaining_next = rr;
    column_index_next  = col;
    row_index_next     = row;
    plane_index_next   = pl;

    end_row = 1'b0;
    push    = 1'b0;
    col_sum = '0;
    room    = '0;
    cnt     = '0;
    pl_sum  = '0;
    row_sum = '0;

    cmd.address = ADDR_W'(ADDR_W'(pl) * ADDR_W'(PLANE_SIZE)
                          + ADDR_W'(row) * ADDR_W'(ROW_STRIDE)
                          + ADDR_W'(col));
    cmd.value   = code_byte;
    cmd.count   = COUNT_W'(1);
    cmd.done    = 1'b0;

    case (ph)
      PH_CTRL: begin
        if (!code_byte[BYTE_W-1]) begin
          phase_next         = PH_LIT;
          run_remaining_next = code_byte + BYTE_W'(1);
        end else begin
          phase_next         = PH_REP;
          run_remaining_next = BYTE_W'(9'd257 - {1'b0, code_byte});
        end
      end
      PH_LIT: begin
        push               = 1'b1;
        col_sum            = {1'b0, col} + (LEN_W+1)'(1);
        run_remaining_next = rr - BYTE_W'(1);
        if (col_sum >= {1'b0, len}) begin
          run_remaining_next = '0;
          end_row            = 1'b1;
        end else begin
          column_index_next = col_sum[LEN_W-1:0];
          if (run_remaining_next == '0) begin
            phase_next = PH_CTRL;
          end
        end
      end
      PH_REP: begin
        push = 1'b1;
        room = (len > col) ? (len - col) : LEN_W'(1);
        if (rr > BYTE_W'(room)) begin
          cnt = room;
        end else if (rr == '0) begin
          cnt = COUNT_W'(1);
        end else begin
          cnt = rr[COUNT_W-1:0];
        end
        cmd.count          = cnt;
        col_sum            = {1'b0, col} + (LEN_W+1)'(cnt);
        run_remaining_next = '0;
        if (col_sum >= {1'b0, len}) begin
          end_row = 1'b1;
        end else begin
          column_index_next = col_sum[LEN_W-1:0];
          phase_next        = PH_CTRL;
        end
      end
      default: begin
        // image complete: drop the byte
      end
    endcase

    if (end_row) begin
      column_index_next = '0;
      pl_sum            = PLANES_W'(pl) + PLANES_W'(1);
      phase_next        = PH_CTRL;
      if (pl_sum >= planes) begin
        plane_index_next = '0;
        row_sum          = {1'b0, row} + (ROWS_W+1)'(1);
        row_index_next   = row_sum[ROWS_W-1:0];
        if (row_sum >= {1'b0, rows}) begin
          phase_next = PH_DONE;
          cmd.done   = 1'b1;
        end
      end else begin
        plane_index_next = pl_sum[PLANE_W-1:0];
      end
    end

    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= LEN_W'(40);
      row_count     <= ROWS_W'(256);
      plane_count   <= PLANES_W'(2);
      phase         <= PH_CTRL;
      run_remaining <= '0;
      column_index  <= '0;
      row_index     <= '0;
      plane_index   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_LENGTH:  row_length  <= cfg_data[LEN_W-1:0];
          REG_ROW_COUNT:   row_count   <= cfg_data[ROWS_W-1:0];
          REG_PLANE_COUNT: plane_count <= cfg_data[PLANES_W-1:0];
          default: begin
            // unknown index: drop the write
          end
        endcase
      end
      if (take) begin
        phase         <= phase_next;
        run_remaining <= run_remaining_next;
        column_index  <= column_index_next;
        row_index     <= row_index_next;
        plane_index   <= plane_index_next;
      end
    end
  end

  `ILBMPB_ASSERT_NOW(a_burst_in_row, clk, rst, push, (cmd.count != '0) && (cmd.count <= len), "burst length outside the row")

endmodule

// File: hdl/ilbmpb_queue.sv
// ----------------------------------------------------------------------------
// ilbmpb_queue
// Short burst queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "ilbm_body_packbits_decoder_unit_defines.svh"

module ilbmpb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ilbmpb_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ilbmpb_pkg::cmd_t head_cmd
);
  import ilbmpb_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill, fill_next;

  assign full       = (fill == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      fill_next = fill - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `ILBMPB_ASSERT_NOW(a_no_overflow, clk, rst, push, !full || pop, "burst pushed into a full queue")
  `ILBMPB_ASSERT_NOW(a_no_underflow, clk, rst, pop, head_valid, "burst popped from an empty queue")
  `ILBMPB_ASSERT_NEXT(a_fill_tracks, clk, rst, push && !pop, fill == $past(fill) + QUEUE_CNT_W'(1), "fill count lost a push")

endmodule

// File: hdl/ilbmpb_back.sv
// ----------------------------------------------------------------------------
// ilbmpb_back
// Expands each write burst into one output word per decoded byte.
// ----------------------------------------------------------------------------
`include "ilbm_body_packbits_decoder_unit_defines.svh"

module ilbmpb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  ilbmpb_pkg::cmd_t              head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ilbmpb_pkg::ADDR_W-1:0] byte_address,
  output logic [ilbmpb_pkg::BYTE_W-1:0] byte_value,
  output logic                          run_last,
  output logic                          image_done
);
  import ilbmpb_pkg::*;

  logic               busy;
  logic [COUNT_W-1:0] remaining;
  logic [ADDR_W-1:0]  address;
  logic [BYTE_W-1:0]  value;
  logic               done;
  logic               fire;
  logic               last;

  assign fire = busy && out_ready;
  assign last = (remaining == COUNT_W'(1));
  // take the next burst as soon as the current one hands off its last word
  assign pop  = head_valid && (!busy || (fire && last));

  assign out_valid    = busy;
  assign byte_address = address;
  assign byte_value   = value;
  assign run_last     = last;
  assign image_done   = done && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= head_cmd.count;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end
      remaining <= remaining - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      address <= head_cmd.address;
      value   <= head_cmd.value;
      done    <= head_cmd.done;
    end else if (fire) begin
      address <= address + ADDR_W'(1);
    end
  end

  `ILBMPB_ASSERT_NOW(a_busy_has_words, clk, rst, busy, remaining != '0, "active burst with no words left")
  `ILBMPB_ASSERT_NEXT(a_drain_idle, clk, rst, fire && last && !head_valid, !busy, "output still valid after last word")

endmodule

// File: hdl/ilbm_body_packbits_decoder_unit.sv
// ----------------------------------------------------------------------------
// ilbm_body_packbits_decoder_unit
// PackBits body decoder for interleaved planar images.
// ----------------------------------------------------------------------------
// Takes one compressed body byte per cycle while the burst queue has room and
// writes decoded bytes with their planar buffer address (plane * 10240 + row *
// 40 + column). Control bytes give no output and each literal byte gives one
// output word; a repeat value byte turns into a burst of 1 to 40 output words,
// one per cycle while out_ready is high, produced by the back end while the
// front end keeps taking bytes until its two-entry burst queue is full. A data
// byte passes through the burst queue and the back-end registers before its
// first word appears. Input and output overlap, so over a stretch the busier
// side sets the pace, and the front end stalls once two bursts wait behind it.
// Rows are clipped to row_length; bytes after the final row are dropped until
// frame_start. The configuration port is always ready and is meant to be
// written only while the decoder is idle.
// ----------------------------------------------------------------------------
module ilbm_body_packbits_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ilbmpb_pkg::BYTE_W-1:0]      code_byte,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ilbmpb_pkg::ADDR_W-1:0]      byte_address,
  output logic [ilbmpb_pkg::BYTE_W-1:0]      byte_value,
  output logic                               run_last,
  output logic                               image_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ilbmpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ilbmpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ilbmpb_pkg::*;

  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  ilbmpb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_byte   (code_byte),
    .frame_start (frame_start),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  ilbmpb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ilbmpb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .run_last     (run_last),
    .image_done   (image_done)
  );

endmodule

// File: verif/ilbm_body_packbits_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// ilbm_body_packbits_decoder_unit_test
// Self-checking bench for the PackBits body decoder.
// ----------------------------------------------------------------------------
// Feeds directed and random compressed body streams under several row length,
// row count and plane settings, stalls both channels at random, and checks
// every written word against an in-bench decoder that tracks the decode
// phase, run length, column, row and plane.
// ----------------------------------------------------------------------------
module ilbm_body_packbits_decoder_unit_test;
  import ilbmpb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
    bit                run_last;
    bit                image_done;
  } plane_write_t;

  class decoded_byte_board;
    logic [LEN_W-1:0]    row_length  = 6'd40;
    logic [ROWS_W-1:0]   row_count   = 9'd256;
    logic [PLANES_W-1:0] plane_count = 2'd2;
    phase_t              phase       = PH_CTRL;
    int                  run_left    = 0;
    int                  column      = 0;
    int                  row         = 0;
    int                  plane       = 0;
    plane_write_t        pending_writes[$];
    int                  used_bytes  = 0;
    int                  errors      = 0;

    function void report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endfunction

    function int line_len();
      int n = row_length;
      if (n > LEN_MAX) n = LEN_MAX;
      if (n < 1) n = 1;
      return n;
    endfunction

    function int image_rows();
      int n = row_count;
      if (n > ROWS_MAX) n = ROWS_MAX;
      if (n < 1) n = 1;
      return n;
    endfunction

    function int image_planes();
      int n = plane_count;
      if (n > PLANES_MAX) n = PLANES_MAX;
      if (n < 1) n = 1;
      return n;
    endfunction

    function logic [ADDR_W-1:0] write_address();
      int a;
      a = plane * PLANE_SIZE + row * ROW_STRIDE + column;
      return a[ADDR_W-1:0];
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROW_LENGTH:  row_length  = data[LEN_W-1:0];
        REG_ROW_COUNT:   row_count   = data[ROWS_W-1:0];
        REG_PLANE_COUNT: plane_count = data[PLANES_W-1:0];
        default: ;
      endcase
    endfunction

    // Step to the next plane or row; return 1 when the image is complete.
    function bit close_row();
      column = 0;
      plane++;
      if (plane >= image_planes()) begin
        plane = 0;
        row++;
        if (row >= image_rows()) begin
          phase = PH_DONE;
          return 1;
        end
      end
      phase = PH_CTRL;
      return 0;
    endfunction

    function void take_code_byte(logic [BYTE_W-1:0] b, logic restart);
      int           len;
      int           room;
      int           cnt;
      plane_write_t w;
      len = line_len();
      used_bytes++;
      if (restart) begin
        phase    = PH_CTRL;
        run_left = 0;
        column   = 0;
        row      = 0;
        plane    = 0;
      end
      if (phase == PH_DONE) return;
      if (phase == PH_CTRL) begin
        if (b < 8'd128) begin
          phase    = PH_LIT;
          run_left = b + 1;
        end else begin
          phase    = PH_REP;
          run_left = 257 - b;
        end
        return;
      end
      if (phase == PH_LIT) begin
        w.address    = write_address();
        w.value      = b;
        w.run_last   = 1;
        w.image_done = 0;
        column++;
        run_left = (run_left - 1) & 8'hFF;
        if (column >= len) begin
          run_left     = 0;
          w.image_done = close_row();
        end else if (run_left == 0) begin
          phase = PH_CTRL;
        end
        pending_writes.push_back(w);
        return;
      end
      // Repeat value: clip the run at the row end.
      room = (len > column) ? len - column : 1;
      cnt  = (run_left > room) ? room : run_left;
      if (cnt < 1) cnt = 1;
      for (int i = 0; i < cnt; i++) begin
        w.address    = write_address();
        w.value      = b;
        w.run_last   = 0;
        w.image_done = 0;
        column++;
        if (i == cnt - 1) begin
          w.run_last = 1;
          run_left   = 0;
          if (column >= len) w.image_done = close_row();
          else phase = PH_CTRL;
        end
        pending_writes.push_back(w);
      end
    endfunction

    function void check_write(logic [ADDR_W-1:0] address, logic [BYTE_W-1:0] value,
                              logic run_last, logic image_done);
      plane_write_t w;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected word addr=%0d value=%02h", address, value));
        return;
      end
      w = pending_writes.pop_front();
      if (address !== w.address)
        report($sformatf("byte_address %0d, expected %0d", address, w.address));
      if (value !== w.value)
        report($sformatf("byte_value %02h, expected %02h at addr %0d", value, w.value,
                         w.address));
      if (run_last !== w.run_last)
        report($sformatf("run_last %b, expected %b at addr %0d", run_last, w.run_last,
                         w.address));
      if (image_done !== w.image_done)
        report($sformatf("image_done %b, expected %b at addr %0d", image_done,
                         w.image_done, w.address));
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      code_byte   = '0;
  logic                   frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [ADDR_W-1:0]      byte_address;
  logic [BYTE_W-1:0]      byte_value;
  logic                   run_last;
  logic                   image_done;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  decoded_byte_board board;
  bit                calm = 1'b0;

  ilbm_body_packbits_decoder_unit i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 30);
  end

  // Track every handshake in one place so prediction and checking stay ordered.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) board.take_code_byte(code_byte, frame_start);
      if (out_valid && out_ready)
        board.check_write(byte_address, byte_value, run_last, image_done);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] code, input bit restart);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    code_byte   <= code;
    frame_start <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted word, then let the back end go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Mostly well-formed runs with random content, plus stray bytes and restarts.
  task automatic send_packet(input bit restart);
    int kind;
    int n;
    bit fs;
    fs   = restart || (board.phase == PH_DONE) || ($urandom_range(99) < 3);
    kind = $urandom_range(99);
    if (kind < 12 && !restart) begin
      send_byte(BYTE_W'($urandom_range(255)), $urandom_range(99) < 10);
    end else if (kind < 56) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
      send_byte(n[BYTE_W-1:0], fs);
      repeat (n + 1) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    end else begin
      send_byte(BYTE_W'($urandom_range(255, 128)), fs);
      send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    int len;
    int rows;
    int planes;
    int goal;
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two rows of two planes, four bytes each.
    write_register(REG_ROW_LENGTH, 9'd4);
    write_register(REG_ROW_COUNT, 9'd2);
    write_register(REG_PLANE_COUNT, 9'd2);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h81, 1'b0);   // repeat clipped at the row end
    send_byte(8'h55, 1'b0);
    send_byte(8'h7F, 1'b0);   // literal clipped after four words
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'hFF, 1'b0);   // leftover literal byte read as control
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h3C, 1'b0);   // completes the image
    send_byte(8'h00, 1'b0);   // ignored after the last row
    send_byte(8'h12, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h34, 1'b0);
    settle();

    // Shrink everything mid image, below range, and poke the unused index.
    write_register(REG_ROW_LENGTH, 9'd0);
    write_register(REG_ROW_COUNT, 9'd0);
    write_register(REG_PLANE_COUNT, 9'd0);
    write_register(REG_UNUSED, 9'h1FF);
    send_byte(8'h56, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h77, 1'b0);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          len = 5; rows = 3; planes = 2;
        end
        1: begin
          len = 63; rows = 511; planes = 3;
        end
        2: begin
          len = 1; rows = 256; planes = 1;
        end
        default: begin
          len    = $urandom_range(63);
          rows   = $urandom_range(12);
          planes = $urandom_range(3);
        end
      endcase
      calm = (p == 1);
      write_register(REG_ROW_LENGTH, CFG_DATA_W'(len));
      write_register(REG_ROW_COUNT, CFG_DATA_W'(rows));
      write_register(REG_PLANE_COUNT, CFG_DATA_W'(planes));
      goal = board.used_bytes + 110;
      send_packet(1'b1);
      while (board.used_bytes < goal) send_packet(1'b0);
      settle();
    end

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
